[rtl/core/ppi_pkg.sv]
// Shared types, codes and constants of the particle pool integrator.
package ppi_pkg;

	localparam int unsigned KMote     = 58982;
	localparam int unsigned KConfetti = 29491;

	typedef enum logic [1:0] {
		FUNC_SPAWN = 2'd0,
		FUNC_TICK  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_DOT      = 3'd0,
		KIND_CONFETTI = 3'd1,
		KIND_RING     = 3'd2,
		KIND_MOTE     = 3'd3,
		KIND_SPARKLE  = 3'd4
	} kind_t;

	localparam logic [1:0] REG_WIND_SIN  = 2'd0;
	localparam logic [1:0] REG_WIND_COS  = 2'd1;
	localparam logic [1:0] REG_WIND_STR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAWN,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_TICK,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       spawn;     // write the held item at the head
		logic       rd_issue;  // register read of the requested slot
		logic       rd_take;   // capture read data into the result
		logic       tick_go;   // start walking the pool
		logic       clear_out; // result all zero except live count (tick) or slot (read)
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tick_done;
		logic rd_oob;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

[rtl/core/ppi_ctrl.sv]
// Controller state machine of the particle pool integrator.
module ppi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic [1:0]     in_func,
	input  logic           out_fire,
	input  ppi_pkg::stat_t stat,
	output logic           in_ready,
	output logic           out_valid,
	output ppi_pkg::cmd_t  cmd
);
	import ppi_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (func_t'(in_func))
						FUNC_SPAWN: state_nx = ST_SPAWN;
						FUNC_TICK:  state_nx = ST_TICK;
						FUNC_READ:  state_nx = ST_RD_ADDR;
						default:    state_nx = ST_IDLE;
					endcase
				end
			end
			ST_SPAWN:   state_nx = ST_OUT;
			ST_RD_ADDR: state_nx = ST_RD_DATA;
			ST_RD_DATA: state_nx = ST_OUT;
			ST_TICK:    if (stat.tick_done) state_nx = ST_OUT;
			ST_OUT:     if (out_fire) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.tick_go = in_fire && (func_t'(in_func) == FUNC_TICK);
			end
			ST_SPAWN:   cmd.spawn = 1'b1;
			ST_RD_ADDR: cmd.rd_issue = 1'b1;
			ST_RD_DATA: begin
				cmd.rd_take = 1'b1;
				cmd.clear_out = stat.rd_oob;
			end
			ST_TICK:    cmd.clear_out = stat.tick_done;
			ST_OUT:     out_valid = 1'b1;
			default:    ;
		endcase
	end
endmodule

[rtl/core/ppi_datapath.sv]
// Slot stores, integration pipeline and result register.
module ppi_datapath #(
	parameter int NUM_SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ppi_pkg::cmd_t      cmd,
	output ppi_pkg::stat_t     stat,
	input  logic               in_fire,
	input  logic [266:0]       in_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_data,
	output logic [143:0]       res
);
	import ppi_pkg::*;

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// held input item
	logic [266:0] item_q;
	always_ff @(posedge clk) if (in_fire) item_q <= in_data;

	wire logic signed [31:0] i_px = item_q[33:2];
	wire logic signed [31:0] i_py = item_q[65:34];
	wire logic signed [31:0] i_pz = item_q[97:66];
	wire logic signed [31:0] i_vx = item_q[129:98];
	wire logic signed [31:0] i_vy = item_q[161:130];
	wire logic signed [31:0] i_vz = item_q[193:162];
	wire logic [23:0]        i_life = item_q[217:194];
	wire logic [26:0]        i_gk = item_q[244:218];
	wire logic [15:0]        i_dt = item_q[260:245];
	wire logic [5:0]         i_idx = item_q[266:261];

	// configuration
	logic signed [15:0] wsin_q, wcos_q;
	logic [8:0]         wstr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsin_q <= 16'sd10555; wcos_q <= 16'sd12531; wstr_q <= 9'd128;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIND_SIN: wsin_q <= cfg_data;
				REG_WIND_COS: wcos_q <= cfg_data;
				REG_WIND_STR: wstr_q <= (cfg_data[8:0] > 9'd256) ? 9'd256 : cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// slot stores: a life of zero marks a dead slot; valid bits give the reset view
	logic signed [31:0] px_m [NUM_SLOTS];
	logic signed [31:0] py_m [NUM_SLOTS];
	logic signed [31:0] pz_m [NUM_SLOTS];
	logic signed [31:0] vx_m [NUM_SLOTS];
	logic signed [31:0] vy_m [NUM_SLOTS];
	logic signed [31:0] vz_m [NUM_SLOTS];
	logic [23:0]        lf_m [NUM_SLOTS];
	logic [26:0]        gk_m [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] vld_q;
	logic [AW-1:0] head_q;

	// walk: s0 address, s1 read data, s2 gravity/wind products, s3 push*dt and vy, s4 wind, s5 pos products
	logic [AW:0]   rd_cnt_q;
	logic          walk_q;
	logic [AW-1:0] ra;
	logic          r_en;
	logic [6:0]    live_q;

	logic signed [31:0] rpx, rpy, rpz, rvx, rvy, rvz;
	logic [23:0] rlf; logic [26:0] rgk; logic rv;
	always_ff @(posedge clk) begin
		if (r_en) begin
			rpx <= px_m[ra]; rpy <= py_m[ra]; rpz <= pz_m[ra];
			rvx <= vx_m[ra]; rvy <= vy_m[ra]; rvz <= vz_m[ra];
			rlf <= lf_m[ra]; rgk <= gk_m[ra];
		end
	end
	always_ff @(posedge clk or negedge arst_n)
		if (!arst_n) rv <= 1'b0; else if (r_en) rv <= vld_q[ra];

	wire logic [AW-1:0] rd_addr = cmd.rd_issue ? i_idx[AW-1:0] : rd_cnt_q[AW-1:0];
	assign ra = rd_addr;
	assign r_en = cmd.rd_issue || (walk_q && rd_cnt_q < (AW+1)'(NUM_SLOTS));

	// s1 valid and address
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0] a_s1, a_s2, a_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= 1'b0; rd_cnt_q <= '0; v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			v_s1 <= walk_q && rd_cnt_q < (AW+1)'(NUM_SLOTS);
			v_s2 <= v_s1; v_s3 <= v_s2;
			if (cmd.tick_go) begin walk_q <= 1'b1; rd_cnt_q <= '0; end
			else if (walk_q) begin
				if (rd_cnt_q < (AW+1)'(NUM_SLOTS)) rd_cnt_q <= rd_cnt_q + 1'b1;
				else if (!v_s1 && !v_s2 && !v_s3 && !v_s4 && !v_s5) walk_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		a_s1 <= rd_cnt_q[AW-1:0]; a_s2 <= a_s1; a_s3 <= a_s2;
	end
	assign stat.tick_done = walk_q && rd_cnt_q == (AW+1)'(NUM_SLOTS) && !v_s1 && !v_s2 &&
		!v_s3 && !v_s4 && !v_s5;
	assign stat.rd_oob = ({26'd0, i_idx} >= 32'(NUM_SLOTS));

	// s2: life step and velocity products
	wire logic [23:0] lf1 = rv ? rlf : 24'd0;
	wire logic [2:0]  kd1 = rv ? rgk[26:24] : 3'd0;
	wire logic        alive1 = lf1 != 24'd0;
	wire logic signed [16:0] dts = {1'b0, i_dt};
	wire logic [17:0] kc = (kd1 == KIND_MOTE) ? 18'(KMote) : 18'(KConfetti);
	logic signed [47:0] gdt_s2;
	logic [32:0] push_s2;
	logic live1_s2, mv_s2, wind_s2;
	logic [23:0] lf_s2;
	logic signed [31:0] px_s2, py_s2, pz_s2, vx_s2, vy_s2, vz_s2;
	logic [26:0] gk_s2;
	always_ff @(posedge clk) begin
		gdt_s2 <= 48'(($signed(rv ? rgk[23:0] : 24'd0)) * dts);
		push_s2 <= 33'(kc * wstr_q);
		live1_s2 <= alive1;
		lf_s2 <= (lf1 > {8'd0, i_dt}) ? lf1 - {8'd0, i_dt} : 24'd0;
		mv_s2 <= alive1 && kd1 != KIND_RING;
		wind_s2 <= kd1 == KIND_CONFETTI || kd1 == KIND_MOTE;
		px_s2 <= rv ? rpx : '0; py_s2 <= rv ? rpy : '0; pz_s2 <= rv ? rpz : '0;
		vx_s2 <= rv ? rvx : '0; vy_s2 <= rv ? rvy : '0; vz_s2 <= rv ? rvz : '0;
		gk_s2 <= rv ? rgk : '0;
	end

	// s3: push*dt, new vy
	logic [48:0] pd_s3;
	logic signed [31:0] nvy_s3;
	logic live1_s3, mv_s3, wind_s3;
	logic [23:0] lf_s3;
	logic signed [31:0] px_s3, py_s3, pz_s3, vx_s3, vz_s3;
	logic [26:0] gk_s3;
	always_ff @(posedge clk) begin
		pd_s3 <= 49'(push_s2 * i_dt);
		nvy_s3 <= sat32(64'(vy_s2) - 64'((gdt_s2 + 48'sd32768) >>> 16));
		live1_s3 <= live1_s2; mv_s3 <= mv_s2; wind_s3 <= wind_s2; lf_s3 <= lf_s2;
		px_s3 <= px_s2; py_s3 <= py_s2; pz_s3 <= pz_s2;
		vx_s3 <= vx_s2; vz_s3 <= vz_s2; gk_s3 <= gk_s2;
	end

	// s4: wind x/z products registered; the final vx/vz feed the s5 position products.
	// Wind product is pd (<=2^42) times 16-bit direction, registered before use.
	logic signed [64:0] wx_s4, wz_s4;
	logic signed [31:0] vy_s4, px_s4, py_s4, pz_s4, vx_s4, vz_s4;
	logic live1_s4, mv_s4, wind_s4; logic [23:0] lf_s4; logic [26:0] gk_s4;
	logic [AW-1:0] a_s4;
	always_ff @(posedge clk) begin
		wx_s4 <= $signed({1'b0, pd_s3}) * wsin_q;
		wz_s4 <= $signed({1'b0, pd_s3}) * wcos_q;
		vy_s4 <= nvy_s3; live1_s4 <= live1_s3; mv_s4 <= mv_s3; wind_s4 <= wind_s3;
		lf_s4 <= lf_s3; gk_s4 <= gk_s3; px_s4 <= px_s3; py_s4 <= py_s3; pz_s4 <= pz_s3;
		vx_s4 <= vx_s3; vz_s4 <= vz_s3; a_s4 <= a_s3;
	end
	always_ff @(posedge clk or negedge arst_n)
		if (!arst_n) v_s4 <= 1'b0; else v_s4 <= v_s3;

	wire logic signed [31:0] nvx = wind_s4 ?
		sat32(64'(vx_s4) + 64'((wx_s4 + (65'sd1 <<< 37)) >>> 38)) : vx_s4;
	wire logic signed [31:0] nvz = wind_s4 ?
		sat32(64'(vz_s4) + 64'((wz_s4 + (65'sd1 <<< 37)) >>> 38)) : vz_s4;

	// s5: position products
	logic signed [48:0] mx_s5, my_s5, mz_s5;
	logic signed [31:0] px_s5, py_s5, pz_s5, vx_s5, vy_s5, vz_s5;
	logic live1_s5, mv_s5; logic [23:0] lf_s5; logic [26:0] gk_s5;
	logic [AW-1:0] a_s5;
	always_ff @(posedge clk) begin
		mx_s5 <= nvx * dts; my_s5 <= vy_s4 * dts; mz_s5 <= nvz * dts;
		vx_s5 <= nvx; vy_s5 <= vy_s4; vz_s5 <= nvz;
		px_s5 <= px_s4; py_s5 <= py_s4; pz_s5 <= pz_s4;
		live1_s5 <= live1_s4; mv_s5 <= mv_s4; lf_s5 <= lf_s4; gk_s5 <= gk_s4; a_s5 <= a_s4;
	end
	always_ff @(posedge clk or negedge arst_n)
		if (!arst_n) v_s5 <= 1'b0; else v_s5 <= v_s4;

	wire logic signed [31:0] npx = sat32(64'(px_s5) + 64'((mx_s5 + 49'sd32768) >>> 16));
	wire logic signed [31:0] npy = sat32(64'(py_s5) + 64'((my_s5 + 49'sd32768) >>> 16));
	wire logic signed [31:0] npz = sat32(64'(pz_s5) + 64'((mz_s5 + 49'sd32768) >>> 16));
	wire logic wb = v_s5 && live1_s5;

	// store writes: spawn or walk write-back, never both
	wire logic [AW-1:0] wa = cmd.spawn ? head_q : a_s5;
	always_ff @(posedge clk) begin
		if (cmd.spawn) begin
			px_m[wa] <= i_px; py_m[wa] <= i_py; pz_m[wa] <= i_pz;
			vx_m[wa] <= i_vx; vy_m[wa] <= i_vy; vz_m[wa] <= i_vz;
			lf_m[wa] <= i_life; gk_m[wa] <= i_gk;
		end else if (wb) begin
			lf_m[wa] <= lf_s5; gk_m[wa] <= gk_s5;
			if (mv_s5) begin
				px_m[wa] <= npx; py_m[wa] <= npy; pz_m[wa] <= npz;
				vx_m[wa] <= vx_s5; vy_m[wa] <= vy_s5; vz_m[wa] <= vz_s5;
			end else begin
				px_m[wa] <= px_s5; py_m[wa] <= py_s5; pz_m[wa] <= pz_s5;
				vx_m[wa] <= vx_s5; vy_m[wa] <= vy_s5; vz_m[wa] <= vz_s5;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0; head_q <= '0; live_q <= '0;
		end else begin
			if (cmd.spawn) begin
				vld_q[head_q] <= 1'b1;
				head_q <= (32'(head_q) + 1 >= NUM_SLOTS) ? '0 : head_q + 1'b1;
			end else if (wb) vld_q[a_s5] <= 1'b1;
			if (cmd.tick_go) live_q <= '0;
			else if (wb && lf_s5 != 24'd0) live_q <= live_q + 1'b1;
		end
	end

	// result: slot, alive, kind, x, y, z, life, live count, zero pad on top
	logic [143:0] res_q;
	always_ff @(posedge clk) begin
		if (cmd.spawn)
			res_q <= {7'd0, 7'd0, i_life, i_pz, i_py, i_px, i_gk[26:24],
				i_life != 24'd0, 6'(head_q)};
		else if (cmd.rd_take) begin
			if (cmd.clear_out) res_q <= {7'd0, 7'd0, 24'd0, 96'd0, 3'd0, 1'b0, i_idx};
			else res_q <= {7'd0, 7'd0, lf1, (rv ? rpz : 32'd0), (rv ? rpy : 32'd0),
				(rv ? rpx : 32'd0), kd1, alive1, i_idx};
		end else if (cmd.clear_out)
			res_q <= {7'd0, live_q, 130'd0};
	end
	assign res = res_q;
endmodule

[rtl/core/particle_pool_integrator_unit.sv]
// Top level of the particle pool integrator: ports, controller and datapath.
//
//  channel  | direction | fields
//  s_axis   | in        | tdata: func,pos_x..z,vel_x..z,lifetime,gravity,kind,delta_time,slot_index
//  m_axis   | out       | tdata: slot,alive,kind_out,out_x..z,life_left,live_count
//  cfg      | in        | cfg_we, cfg_idx, cfg_data (wind_sin, wind_cos, wind_strength)
//
// Spawn goes through ST_SPAWN to ST_OUT, read through ST_RD_ADDR and ST_RD_DATA.
// Tick: the slot store read port visits one slot a cycle
// into a five-stage multiply pipeline that writes each slot back.
// Reset clears life through per-slot valid flops; no clearing pass.
// One item is in flight; s_axis_tready drops until m_axis has taken the result.
module particle_pool_integrator_unit #(
	parameter int NUM_SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[1:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, lifetime[23:0],
	// gravity[23:0], kind[2:0], delta_time[15:0], slot_index[5:0], zero pad
	input  logic [271:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// slot[5:0], alive, kind_out[2:0], out_x, out_y, out_z, life_left[23:0],
	// live_count[6:0], zero pad
	output logic [143:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [15:0]  cfg_data
);
	import ppi_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	wire logic in_fire = s_axis_tvalid && s_axis_tready;
	wire logic out_fire = m_axis_tvalid && m_axis_tready;

	ppi_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_func(s_axis_tdata[1:0]), .out_fire, .stat,
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .cmd
	);

	ppi_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .in_fire, .in_data(s_axis_tdata[266:0]),
		.cfg_we, .cfg_idx, .cfg_data, .res(m_axis_tdata)
	);
endmodule

[tb/particle_pool_integrator_unit_test.sv]
// Self-checking testbench of the particle pool integrator: predictor, stimulus and checker.
module particle_pool_integrator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ppi_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000; // cycles with no item moving on either side
	localparam int SETTLE_CYCLES  = 120;  // wait after the last report is back

	// one input item, fields as on s_axis_tdata
	typedef struct {
		func_t              func;
		logic signed [31:0] pos_x, pos_y, pos_z;
		logic signed [31:0] vel_x, vel_y, vel_z;
		logic [23:0]        lifetime;
		logic [23:0]        gravity;
		logic [2:0]         kind;
		logic [15:0]        delta_time;
		logic [5:0]         slot_index;
	} particle_cmd_t;

	// one result item, fields as on m_axis_tdata
	typedef struct {
		logic [5:0]         slot;
		logic               alive;
		logic [2:0]         kind_out;
		logic signed [31:0] out_x, out_y, out_z;
		logic [23:0]        life_left;
		logic [6:0]         live_count;
	} slot_report_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [271:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_idx;
	logic [15:0]  cfg_data;

	particle_pool_integrator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	// shadow copy of the pool and the wind registers
	logic signed [31:0] pool_px[64], pool_py[64], pool_pz[64];
	logic signed [31:0] pool_vx[64], pool_vy[64], pool_vz[64];
	logic [23:0]        pool_life[64];
	logic [26:0]        pool_grav_kind[64];
	logic [5:0]         pool_head;
	longint             wind_x_dir, wind_z_dir, wind_gain;

	slot_report_t pending_reports[$];
	int           mismatches;
	int           idle_cycles;
	bit           no_idling; // stretches where neither side pauses
	int           rx_stall;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---- predictor ----------------------------------------------------------

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round half up, then floor shift
	function automatic longint round_shift(longint v, int sh);
		return (v + (64'sd1 << (sh - 1))) >>> sh;
	endfunction

	function automatic void reset_pool();
		for (int i = 0; i < 64; i++) begin
			pool_px[i] = '0; pool_py[i] = '0; pool_pz[i] = '0;
			pool_vx[i] = '0; pool_vy[i] = '0; pool_vz[i] = '0;
			pool_life[i] = '0; pool_grav_kind[i] = '0;
		end
		pool_head  = '0;
		wind_x_dir = 10555;
		wind_z_dir = 12531;
		wind_gain  = 128;
	endfunction

	function automatic slot_report_t report_of_slot(int i);
		slot_report_t r;
		r = '{default: '0};
		r.slot      = i[5:0];
		r.alive     = (pool_life[i] != 0);
		r.kind_out  = pool_grav_kind[i][26:24];
		r.out_x     = pool_px[i];
		r.out_y     = pool_py[i];
		r.out_z     = pool_pz[i];
		r.life_left = pool_life[i];
		return r;
	endfunction

	// one Euler step over every live slot; returns the number still alive
	function automatic int integrate_pool(longint dt);
		int     live;
		logic [2:0] k;
		longint g, vx, vy, vz, push;
		live = 0;
		for (int i = 0; i < 64; i++) begin
			if (pool_life[i] == 0) continue;
			pool_life[i] = (longint'(pool_life[i]) > dt) ? pool_life[i] - dt[23:0] : '0;
			k = pool_grav_kind[i][26:24];
			if (k != KIND_RING) begin
				g  = longint'($signed(pool_grav_kind[i][23:0]));
				vx = pool_vx[i];
				vy = clamp32(longint'(pool_vy[i]) - round_shift(g * dt, 16));
				vz = pool_vz[i];
				if (k == KIND_CONFETTI || k == KIND_MOTE) begin
					push = (k == KIND_MOTE ? 64'sd58982 : 64'sd29491) * wind_gain * dt;
					vx = clamp32(vx + round_shift(push * wind_x_dir, 38));
					vz = clamp32(vz + round_shift(push * wind_z_dir, 38));
				end
				pool_vx[i] = vx[31:0];
				pool_vy[i] = vy[31:0];
				pool_vz[i] = vz[31:0];
				pool_px[i] = 32'(clamp32(longint'(pool_px[i]) + round_shift(vx * dt, 16)));
				pool_py[i] = 32'(clamp32(longint'(pool_py[i]) + round_shift(vy * dt, 16)));
				pool_pz[i] = 32'(clamp32(longint'(pool_pz[i]) + round_shift(vz * dt, 16)));
			end
			if (pool_life[i] != 0) live++;
		end
		return live;
	endfunction

	// applies an accepted item and queues the report it causes
	function automatic void apply_cmd(particle_cmd_t c);
		slot_report_t r;
		int           h, live;
		r = '{default: '0};
		case (c.func)
			FUNC_SPAWN: begin
				h = pool_head;
				pool_px[h] = c.pos_x; pool_py[h] = c.pos_y; pool_pz[h] = c.pos_z;
				pool_vx[h] = c.vel_x; pool_vy[h] = c.vel_y; pool_vz[h] = c.vel_z;
				pool_life[h] = c.lifetime;
				pool_grav_kind[h] = {c.kind, c.gravity};
				pool_head = pool_head + 6'd1;
				pending_reports.push_back(report_of_slot(h));
			end
			FUNC_TICK: begin
				live = integrate_pool(longint'(c.delta_time));
				r.live_count = live[6:0];
				pending_reports.push_back(r);
			end
			FUNC_READ: pending_reports.push_back(report_of_slot(c.slot_index));
			default: ; // unused func: no report
		endcase
	endfunction

	// ---- checker ------------------------------------------------------------

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		slot_report_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.slot       = m_axis_tdata[5:0];
			got.alive      = m_axis_tdata[6];
			got.kind_out   = m_axis_tdata[9:7];
			got.out_x      = m_axis_tdata[41:10];
			got.out_y      = m_axis_tdata[73:42];
			got.out_z      = m_axis_tdata[105:74];
			got.life_left  = m_axis_tdata[129:106];
			got.live_count = m_axis_tdata[136:130];
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected item, slot", got.slot, 0);
			end else begin
				want = pending_reports.pop_front();
				if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
				if (got.alive != want.alive) report_mismatch("alive", got.alive, want.alive);
				if (got.kind_out != want.kind_out)
					report_mismatch("kind_out", got.kind_out, want.kind_out);
				if (got.out_x != want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
				if (got.out_y != want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
				if (got.out_z != want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
				if (got.life_left != want.life_left)
					report_mismatch("life_left", got.life_left, want.life_left);
				if (got.live_count != want.live_count)
					report_mismatch("live_count", got.live_count, want.live_count);
			end
		end
	end

	// ---- idling and watchdog ------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		m_axis_tready = 1'b0;
		rx_stall = 0;
		forever begin
			@(negedge clk);
			if (no_idling) begin
				m_axis_tready <= 1'b1;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// ---- stimulus helpers ---------------------------------------------------

	// drives one item and waits for it to be taken; valid stays high into a
	// back-to-back item, it is only lowered during a gap
	task automatic send_cmd(particle_cmd_t c);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, c.slot_index, c.delta_time, c.kind, c.gravity, c.lifetime,
			c.vel_z, c.vel_y, c.vel_x, c.pos_z, c.pos_y, c.pos_x, c.func};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		apply_cmd(c);
		gap = no_idling ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// sender holds off until every report is back, then lets a tick finish
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_reports.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		drain();
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		case (idx)
			REG_WIND_SIN: wind_x_dir = longint'($signed(value));
			REG_WIND_COS: wind_z_dir = longint'($signed(value));
			REG_WIND_STR: wind_gain = (value[8:0] > 9'd256) ? 256 : longint'(value[8:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic particle_cmd_t spawn_cmd(logic signed [31:0] p, logic signed [31:0] v,
			logic [23:0] life, logic [23:0] g, logic [2:0] k);
		particle_cmd_t c;
		c = '{func: FUNC_SPAWN, default: '0};
		c.pos_x = p; c.pos_y = -p; c.pos_z = p ^ 32'h5a5a_0000;
		c.vel_x = v; c.vel_y = -v; c.vel_z = v >>> 1;
		c.lifetime = life; c.gravity = g; c.kind = k;
		return c;
	endfunction

	function automatic particle_cmd_t tick_cmd(logic [15:0] dt);
		particle_cmd_t c;
		c = '{func: FUNC_TICK, default: '0};
		c.delta_time = dt;
		return c;
	endfunction

	function automatic particle_cmd_t read_cmd(logic [5:0] idx);
		particle_cmd_t c;
		c = '{func: FUNC_READ, default: '0};
		c.slot_index = idx;
		return c;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			default: return $urandom;
		endcase
	endfunction

	// random content, shaped so that particles live across several ticks
	function automatic particle_cmd_t rand_cmd();
		particle_cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		c.pos_x = rand_word(); c.pos_y = rand_word(); c.pos_z = rand_word();
		c.vel_x = rand_word(); c.vel_y = rand_word(); c.vel_z = rand_word();
		c.lifetime   = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(1, 24'h4_0000));
		c.gravity    = 24'($urandom);
		c.kind       = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		c.delta_time = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16'h1000));
		c.slot_index = 6'($urandom);
		if (r < 45)      c.func = FUNC_SPAWN;
		else if (r < 70) c.func = FUNC_TICK;
		else if (r < 95) c.func = FUNC_READ;
		else             c.func = FUNC_NONE;
		return c;
	endfunction

	// ---- tests --------------------------------------------------------------

	// empty pool after reset: reads report dead zero slots, tick counts none
	task automatic test_reset_state();
		send_cmd(read_cmd(6'd0));
		send_cmd(read_cmd(6'd63));
		send_cmd(tick_cmd(16'hffff));
	endtask

	// every kind, field extremes, saturation of velocity and position
	task automatic test_kinds_and_extremes();
		send_cmd(spawn_cmd(32'sh7fff_0000, 32'sh7fff_ffff, 24'hff_ffff, 24'h7f_ffff, KIND_DOT));
		send_cmd(spawn_cmd(32'sh8000_0000, 32'sh8000_0000, 24'hff_ffff, 24'h80_0000,
			KIND_CONFETTI));
		send_cmd(spawn_cmd(32'sh0001_0000, 32'sh0010_0000, 24'h01_0000, 24'h09_cccc, KIND_RING));
		send_cmd(spawn_cmd(-32'sh0003_0000, 32'sh0002_0000, 24'h02_0000, 24'h00_8000, KIND_MOTE));
		send_cmd(spawn_cmd(32'sh0000_0000, -32'sh0001_0000, 24'h00_8000, 24'h7f_ffff,
			KIND_SPARKLE));
		send_cmd(spawn_cmd(32'sh1234_5678, 32'sh0100_0000, 24'h00_4000, 24'hff_ffff, 3'd7));
		send_cmd(tick_cmd(16'hffff));
		for (int i = 0; i < 6; i++) send_cmd(read_cmd(i[5:0]));
	endtask

	// life running out, zero lifetime, zero dt and the unused func
	task automatic test_life_and_noise();
		particle_cmd_t c;
		send_cmd(spawn_cmd(32'sh0000_1000, 32'sh0000_2000, 24'h00_0001, 24'h00_1000, KIND_MOTE));
		send_cmd(spawn_cmd(32'sh0000_1000, 32'sh0000_2000, 24'h00_0000, 24'h00_1000, KIND_DOT));
		send_cmd(tick_cmd(16'h0000));
		send_cmd(tick_cmd(16'h0001));
		c = rand_cmd();
		c.func = FUNC_NONE;
		send_cmd(c);
		send_cmd(read_cmd(6'd6));
		send_cmd(read_cmd(6'd7));
	endtask

	task automatic test_random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) no_idling = ($urandom_range(0, 3) == 0);
			send_cmd(rand_cmd());
		end
		no_idling = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_data      = '0;
		no_idling     = 1'b0;
		mismatches    = 0;
		idle_cycles   = 0;
		reset_pool();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_kinds_and_extremes();
		test_life_and_noise();
		test_random_phase(150);

		// equal wind along x and -z, strength above range clamps
		write_reg(REG_WIND_SIN, 16'sd16384);
		write_reg(REG_WIND_COS, -16'sd16384);
		write_reg(REG_WIND_STR, 16'h01ff);
		test_random_phase(150);

		// direction beyond unit range, wind switched off and then small
		write_reg(REG_WIND_SIN, 16'h8000);
		write_reg(REG_WIND_COS, 16'h7fff);
		write_reg(REG_WIND_STR, 16'h0000);
		test_random_phase(40);
		write_reg(REG_WIND_STR, 16'hfe01);
		test_random_phase(110);

		drain();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/core/ppi_pkg.sv
rtl/core/ppi_ctrl.sv
rtl/core/ppi_datapath.sv
rtl/core/particle_pool_integrator_unit.sv
tb/particle_pool_integrator_unit_test.sv
